// File: hdl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types, constants and the policy compare for the task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

	localparam int WORKERS_DEF     = 8;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int MAX_RESULTS     = 16;
	localparam int NCNT_W          = 5;
	// wide enough for the deepest queue allowed
	localparam int SLOT_W          = 6;

	localparam logic [1:0] POL_FCFS = 2'd0;
	localparam logic [1:0] POL_SJF  = 2'd1;

	typedef struct packed {
		logic [23:0] arr;
		logic [15:0] dur;
		logic [15:0] id;
	} entry_t;

	// selection token passed down the cell row
	typedef struct packed {
		logic              found;
		entry_t            best;
		logic [SLOT_W-1:0] idx;
		logic              free_found;
		logic [SLOT_W-1:0] free_idx;
	} token_t;

	// write or clear of one slot of the selected worker
	typedef struct packed {
		logic              wr;
		logic              clr;
		logic [SLOT_W-1:0] idx;
		entry_t            data;
	} cmd_t;

	// true if a is served before b
	function automatic logic better(input logic [1:0] pol, input entry_t a, input entry_t b);
		logic r;
		r = a.id > b.id;
		if (pol == POL_FCFS) begin
			if (a.arr != b.arr) r = a.arr < b.arr;
		end else if (pol == POL_SJF) begin
			if (a.dur != b.dur) r = a.dur < b.dur;
		end else begin
			if (a.dur != b.dur) r = a.dur > b.dur;
		end
		return r;
	endfunction

endpackage

// File: hdl/pts_cell.sv
// ----------------------------------------------------------------------------
// pts_cell
// One queue slot for every worker, plus one stage of the selection row.
// ----------------------------------------------------------------------------
module pts_cell #(
	parameter int WORKERS = pts_pkg::WORKERS_DEF,
	parameter int IDX     = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [2:0]      worker,
	input  logic [1:0]      policy,
	input  pts_pkg::cmd_t   cmd,
	input  pts_pkg::token_t tok_in,
	output pts_pkg::token_t tok_out
);
	import pts_pkg::*;

	localparam int WW = (WORKERS > 1) ? $clog2(WORKERS) : 1;

	entry_t             ent_q [WORKERS];
	logic [WORKERS-1:0] vld_q;
	token_t             tok_q;
	token_t             nxt;
	logic [WW-1:0]      wi;
	logic               hit;

	assign wi  = worker[WW-1:0];
	assign hit = (cmd.idx == SLOT_W'(IDX));

	always_comb begin
		nxt = tok_in;
		if (vld_q[wi] && (!tok_in.found || better(policy, ent_q[wi], tok_in.best))) begin
			nxt.found = 1'b1;
			nxt.best  = ent_q[wi];
			nxt.idx   = SLOT_W'(IDX);
		end
		if (!vld_q[wi] && !tok_in.free_found) begin
			nxt.free_found = 1'b1;
			nxt.free_idx   = SLOT_W'(IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (hit && cmd.wr) begin
			vld_q[wi] <= 1'b1;
		end else if (hit && cmd.clr) begin
			vld_q[wi] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hit && cmd.wr) begin
			ent_q[wi] <= cmd.data;
		end
		tok_q <= nxt;
	end

	assign tok_out = tok_q;

endmodule

// File: hdl/policy_task_scheduler.sv
// ----------------------------------------------------------------------------
// policy_task_scheduler
// Non-preemptive per-worker scheduler with FCFS / SJF / LJF queue policies.
// ----------------------------------------------------------------------------
// A request scans the cell row, decides and flushes a result, and repeats the
// scan for each completed task; a stalled sink holds the flush and finish steps.
// One request is in work at a time; the last result may still wait in the
// output register while the next request is already taken.
// Reset clears all slot valid bits, sets every busy-until tick to 1 and
// clears the policy table; slot contents are not reset.
// ----------------------------------------------------------------------------
module policy_task_scheduler #(
	parameter int WORKERS     = pts_pkg::WORKERS_DEF,
	parameter int QUEUE_DEPTH = pts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // worker[2:0], arrival_time[26:3], duration[42:27],
	                               // task_id[58:43]
	input  logic        s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // worker_out[2:0], finish_time[34:3],
	                               // task_arrival[58:35], task_out[74:59]
	output logic        m_tuser,   // status
	output logic        m_tlast,   // last
	input  logic        policy_we,
	input  logic [15:0] policy_wdata
);
	import pts_pkg::*;

	localparam int CW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_FLUSH  = 3'd3;
	localparam logic [2:0] S_FIN    = 3'd4;

	typedef struct packed {
		logic        status;
		logic [2:0]  worker;
		logic [31:0] fin;
		logic [23:0] arr;
		logic [15:0] id;
	} res_t;

	logic [2:0]        state_q;
	logic [CW-1:0]     cnt_q;
	logic [NCNT_W-1:0] n_q;
	logic [15:0]       policy_q;
	logic [31:0]       busy_q [8];

	// latched request
	logic        kind_q;
	logic [2:0]  worker_q;
	entry_t      req_q;

	// result held back until it is known whether it is the last one
	res_t        hold_q;
	logic        hold_v_q;
	res_t        nres_q;
	logic        nres_v_q;
	logic        end_q;

	res_t        out_q;
	logic        out_v_q;
	logic        out_last_q;

	token_t      tok [QUEUE_DEPTH];
	token_t      tail;
	cmd_t        cmd;
	logic [1:0]  policy;
	logic        out_free;
	logic        out_load;
	logic        serve;
	logic [31:0] busy;
	logic [31:0] start;
	logic [32:0] sum;
	logic [31:0] fin;

	assign tail     = tok[QUEUE_DEPTH-1];
	assign policy   = policy_q[{worker_q, 1'b0} +: 2];
	assign out_free = !out_v_q || m_tready;
	assign busy     = busy_q[worker_q];

	// load the output register from the held result
	assign out_load = ((state_q == S_FLUSH) && nres_v_q && hold_v_q && out_free) ||
		((state_q == S_FIN) && hold_v_q && out_free);

	// Pop when a task is queued, the result budget allows, and for an arrival
	// the worker is already free at the arrival tick.
	assign serve = tail.found && (n_q < NCNT_W'(MAX_RESULTS)) &&
		(kind_q || (busy <= {8'd0, req_q.arr}));

	assign start = (busy > {8'd0, tail.best.arr}) ? busy : {8'd0, tail.best.arr};
	assign sum   = {1'b0, start} + {17'd0, tail.best.dur};
	assign fin   = sum[32] ? '1 : sum[31:0];

	// slot update for the selected worker, issued in the decide cycle
	always_comb begin
		cmd      = '0;
		cmd.data = req_q;
		if (state_q == S_DECIDE) begin
			if (serve) begin
				cmd.clr = 1'b1;
				cmd.idx = tail.idx;
			end else if (!kind_q && tail.free_found) begin
				cmd.wr  = 1'b1;
				cmd.idx = tail.free_idx;
			end
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				pts_cell #(.WORKERS(WORKERS), .IDX(gi)) u_cell (
					.clk(clk), .arst_n(arst_n), .worker(worker_q), .policy(policy),
					.cmd(cmd), .tok_in('0), .tok_out(tok[gi])
				);
			end else begin : g_body
				pts_cell #(.WORKERS(WORKERS), .IDX(gi)) u_cell (
					.clk(clk), .arst_n(arst_n), .worker(worker_q), .policy(policy),
					.cmd(cmd), .tok_in(tok[gi-1]), .tok_out(tok[gi])
				);
			end
		end
	endgenerate

	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			n_q        <= '0;
			policy_q   <= '0;
			hold_v_q   <= 1'b0;
			nres_v_q   <= 1'b0;
			end_q      <= 1'b0;
			out_v_q    <= 1'b0;
			out_last_q <= 1'b0;
			for (int i = 0; i < 8; i++) busy_q[i] <= 32'd1;
		end else begin
			if (policy_we) policy_q <= policy_wdata;
			// fill the output register, or drop it once the sink has taken it
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						kind_q   <= s_tuser;
						worker_q <= s_tdata[2:0];
						req_q    <= {s_tdata[26:3], s_tdata[42:27], s_tdata[58:43]};
						n_q      <= '0;
						cnt_q    <= '0;
						hold_v_q <= 1'b0;
						// an index past the last worker is ignored
						if ({1'b0, s_tdata[2:0]} < 4'(WORKERS)) state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (cnt_q == CW'(QUEUE_DEPTH - 1)) begin
						cnt_q   <= '0;
						state_q <= S_DECIDE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DECIDE: begin
					end_q <= !serve;
					if (serve) begin
						busy_q[worker_q] <= fin;
						n_q              <= n_q + 1'b1;
						nres_q           <= '{1'b0, worker_q, fin, tail.best.arr, tail.best.id};
						nres_v_q         <= 1'b1;
					end else if (!kind_q && !tail.free_found &&
							(n_q < NCNT_W'(MAX_RESULTS))) begin
						n_q      <= n_q + 1'b1;
						nres_q   <= '{1'b1, worker_q, 32'd0, req_q.arr, req_q.id};
						nres_v_q <= 1'b1;
					end else begin
						nres_v_q <= 1'b0;
					end
					state_q <= S_FLUSH;
				end
				S_FLUSH: begin
					if (!nres_v_q) begin
						state_q <= S_FIN;
					end else if (!hold_v_q || out_free) begin
						if (hold_v_q) begin
							out_q      <= hold_q;
							out_last_q <= 1'b0;
						end
						hold_q   <= nres_q;
						hold_v_q <= 1'b1;
						state_q  <= end_q ? S_FIN : S_SCAN;
					end
				end
				S_FIN: begin
					if (!hold_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_q      <= hold_q;
						out_last_q <= 1'b1;
						hold_v_q   <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {5'd0, out_q.id, out_q.arr, out_q.fin, out_q.worker};
	assign m_tuser  = out_q.status;
	assign m_tlast  = out_last_q;

endmodule

// File: tb/policy_task_scheduler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// policy_task_scheduler_tb
// Self-checking bench for the task scheduler: a directed request table,
// then bursts of random arrivals and drains against a behavioral scheduler.
// ----------------------------------------------------------------------------
module policy_task_scheduler_tb;

	import pts_pkg::*;

	localparam int NW     = 8;
	localparam int DEPTH  = 16;
	localparam int NRAND  = 380;
	localparam int WD_MAX = 40000;
	localparam logic KIND_TASK  = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;
	localparam logic ST_DONE = 1'b0;
	localparam logic ST_DROP = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [2:0]  worker;
		logic [23:0] arr;
		logic [15:0] dur;
		logic [15:0] id;
	} request_t;

	typedef struct packed {
		logic        status;
		logic [2:0]  worker;
		logic [31:0] finish;
		logic [23:0] arr;
		logic [15:0] id;
		logic        last;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        policy_we = 1'b0;
	logic [15:0] policy_wdata = '0;

	policy_task_scheduler u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast), .policy_we(policy_we), .policy_wdata(policy_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// behavioral scheduler state
	entry_t      slot_q   [NW][DEPTH];
	logic        slot_vld [NW][DEPTH];
	logic [31:0] busy_q   [NW];
	logic [15:0] pol_shadow;

	outcome_t expected_q[$];
	int       errors = 0;
	int       idle_cycles = 0;
	logic     stall_on = 1'b0;

	function automatic logic serves_first(logic [1:0] pol, entry_t a, entry_t b);
		if (pol == POL_FCFS && a.arr != b.arr) return a.arr < b.arr;
		if (pol == POL_SJF && a.dur != b.dur) return a.dur < b.dur;
		if (pol != POL_FCFS && pol != POL_SJF && a.dur != b.dur) return a.dur > b.dur;
		return a.id > b.id;
	endfunction

	function automatic int pick_slot(int w);
		int best;
		logic [1:0] pol;
		best = -1;
		pol = pol_shadow[2*w +: 2];
		for (int i = 0; i < DEPTH; i++)
			if (slot_vld[w][i] && (best < 0 || serves_first(pol, slot_q[w][i], slot_q[w][best])))
				best = i;
		return best;
	endfunction

	task automatic complete_slot(int w, int s);
		logic [32:0] start, fin;
		outcome_t o;
		start = (busy_q[w] > {8'd0, slot_q[w][s].arr}) ? {1'b0, busy_q[w]} :
			{9'd0, slot_q[w][s].arr};
		fin = start + {17'd0, slot_q[w][s].dur};
		if (fin[32]) fin = 33'hFFFFFFFF;
		busy_q[w] = fin[31:0];
		slot_vld[w][s] = 1'b0;
		o = '{ST_DONE, 3'(w), fin[31:0], slot_q[w][s].arr, slot_q[w][s].id, 1'b0};
		expected_q.insert(expected_q.size(), o);
	endtask

	// work out the results of one request and queue them
	task automatic schedule_request(request_t r);
		int n, s, w, base;
		outcome_t o;
		n = 0;
		w = r.worker;
		base = expected_q.size();
		if (r.kind == KIND_DRAIN) begin
			s = pick_slot(w);
			while (n < MAX_RESULTS && s >= 0) begin
				complete_slot(w, s);
				n++;
				s = pick_slot(w);
			end
		end else begin
			s = (busy_q[w] <= {8'd0, r.arr}) ? pick_slot(w) : -1;
			while (n < MAX_RESULTS && s >= 0) begin
				complete_slot(w, s);
				n++;
				s = (busy_q[w] <= {8'd0, r.arr}) ? pick_slot(w) : -1;
			end
			s = -1;
			for (int i = 0; i < DEPTH; i++)
				if (s < 0 && !slot_vld[w][i]) s = i;
			if (s >= 0) begin
				slot_q[w][s] = '{r.arr, r.dur, r.id};
				slot_vld[w][s] = 1'b1;
			end else if (n < MAX_RESULTS) begin
				o = '{ST_DROP, r.worker, 32'd0, r.arr, r.id, 1'b0};
				expected_q.insert(expected_q.size(), o);
				n++;
			end
		end
		if (n > 0) expected_q[base + n - 1].last = 1'b1;
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// check each accepted result against the oldest expectation
	always @(posedge clk) begin
		outcome_t e;
		if (m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result", m_tdata[34:3], 32'd0);
			end else begin
				e = expected_q.pop_front();
				if (m_tuser != e.status)
					report_mismatch("status", 32'(m_tuser), 32'(e.status));
				if (m_tdata[2:0] != e.worker)
					report_mismatch("worker", 32'(m_tdata[2:0]), 32'(e.worker));
				if (m_tdata[34:3] != e.finish)
					report_mismatch("finish", m_tdata[34:3], e.finish);
				if (m_tdata[58:35] != e.arr)
					report_mismatch("arrival", 32'(m_tdata[58:35]), 32'(e.arr));
				if (m_tdata[74:59] != e.id)
					report_mismatch("task id", 32'(m_tdata[74:59]), 32'(e.id));
				if (m_tlast != e.last)
					report_mismatch("last", 32'(m_tlast), 32'(e.last));
			end
		end
	end

	// receiver: stretches of stalls alternate with free-flowing stretches
	always @(posedge clk) begin
		if ($urandom_range(0, 15) == 0) stall_on <= ~stall_on;
		m_tready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
	end

	// watchdog: end the run if nothing is accepted for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WD_MAX) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// drive one request and hold it until it is accepted
	task automatic send_request(request_t r);
		s_tvalid <= 1'b1;
		s_tuser  <= r.kind;
		s_tdata  <= {5'd0, r.id, r.dur, r.arr, r.worker};
		schedule_request(r);
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic pause_request(int n);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// wait for all results, then let the block settle before a register write
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_policy(logic [15:0] v);
		policy_we    <= 1'b1;
		policy_wdata <= v;
		@(posedge clk);
		policy_we <= 1'b0;
		pol_shadow = v;
	endtask

	function automatic request_t rand_request(int wmax);
		request_t r;
		r.kind   = ($urandom_range(0, 9) == 0) ? KIND_DRAIN : KIND_TASK;
		r.worker = 3'($urandom_range(0, wmax));
		r.arr    = ($urandom_range(0, 19) == 0) ? 24'($urandom) : 24'($urandom_range(0, 3000));
		r.dur    = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
		r.id     = 16'($urandom);
		return r;
	endfunction

	request_t directed_tab[$];
	outcome_t want_tab[$];
	logic     want_on[$];

	task automatic add_row(request_t r, logic chk, outcome_t w);
		directed_tab.insert(directed_tab.size(), r);
		want_on.insert(want_on.size(), chk);
		want_tab.insert(want_tab.size(), w);
	endtask

	initial begin
		request_t r;
		outcome_t none;
		int bursts;
		none = '0;
		for (int w = 0; w < NW; w++) begin
			busy_q[w] = 32'd1;
			for (int i = 0; i < DEPTH; i++) slot_vld[w][i] = 1'b0;
		end
		pol_shadow = '0;

		// directed table: after reset busy-until is 1, zero duration finishes at start
		add_row('{KIND_TASK, 3'd0, 24'd0, 16'd0, 16'h0001}, 1'b0, none);
		add_row('{KIND_TASK, 3'd0, 24'd5, 16'd10, 16'h0002}, 1'b1,
			'{ST_DONE, 3'd0, 32'd1, 24'd0, 16'h0001, 1'b1});
		add_row('{KIND_DRAIN, 3'd0, 24'd0, 16'd0, 16'd0}, 1'b1,
			'{ST_DONE, 3'd0, 32'd15, 24'd5, 16'h0002, 1'b1});
		// drain of an empty queue gives nothing
		add_row('{KIND_DRAIN, 3'd3, 24'hFFFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, none);
		// fill worker 7 at the largest arrival and duration, then overflow it
		for (int i = 0; i < DEPTH; i++)
			add_row('{KIND_TASK, 3'd7, 24'hFFFFFF, 16'hFFFF, 16'(i)}, 1'b0, none);
		add_row('{KIND_TASK, 3'd7, 24'hFFFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, none);
		add_row('{KIND_TASK, 3'd7, 24'hFFFFFF, 16'hFFFF, 16'hFFFE}, 1'b1,
			'{ST_DROP, 3'd7, 32'd0, 24'hFFFFFF, 16'hFFFE, 1'b1});
		add_row('{KIND_DRAIN, 3'd7, 24'd0, 16'd0, 16'd0}, 1'b0, none);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < directed_tab.size(); k++) begin
			send_request(directed_tab[k]);
			if (want_on[k] && expected_q[expected_q.size()-1] != want_tab[k]) begin
				$display("directed row %0d disagrees with typed result", k);
				errors++;
			end
		end

		// random phases under several policy settings, extremes first
		for (int p = 0; p < 5; p++) begin
			drain_results();
			case (p)
				0: write_policy(16'h5555);
				1: write_policy(16'hAAAA);
				2: write_policy(16'hFFFF);
				3: write_policy(16'($urandom));
				default: write_policy(16'h0000);
			endcase
			bursts = 0;
			while (bursts < NRAND / 5) begin
				for (int b = $urandom_range(1, 12); b > 0 && bursts < NRAND / 5; b--) begin
					// few workers, except in the third phase, so queues fill and policies matter
					r = rand_request(p == 2 ? 7 : 2);
					send_request(r);
					bursts++;
				end
				pause_request($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40));
			end
			if (p == 1) begin
				// hold off new requests until every result is back
				s_tvalid <= 1'b0;
				while (expected_q.size() != 0) @(posedge clk);
			end
		end
		for (int w = 0; w < NW; w++)
			send_request('{KIND_DRAIN, 3'(w), 24'd0, 16'd0, 16'd0});
		s_tvalid <= 1'b0;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
